@@ rtl/deq_pkg.sv @@
// Shared types, constants and ring arithmetic for the double-ended queue.
package deq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W    = CNT_W + 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_COUNT      = 3'd4;
  localparam logic [2:0] OP_DUMP       = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] push_value;
  } req_item_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic [6:0]         occupancy;
    logic [1:0]         status;
    logic               last_result;
  } rsp_item_t;

  typedef struct packed {
    logic        wr_en;
    idx_t        wr_addr;
    logic [31:0] wr_data;
    logic        rd_en;
    idx_t        rd_addr;
  } mem_req_t;

  // base + off modulo CAPACITY, both operands below CAPACITY
  function automatic idx_t ring_pos(idx_t base, cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return idx_t'(sum);
  endfunction

  // base - 1 modulo CAPACITY
  function automatic idx_t ring_dec(idx_t base);
    idx_t res;
    if (base == '0) begin
      res = idx_t'(CAPACITY - 1);
    end else begin
      res = base - 1'b1;
    end
    return res;
  endfunction

endpackage

@@ rtl/deq_ram.sv @@
// Element store: one write port, one read port, registered read data.
module deq_ram
  import deq_pkg::*;
(
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rd_data
);

  logic [31:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ rtl/double_ended_queue.sv @@
// Double-ended queue top level: opcode sequencer, ring pointers, result register.
// A result is loaded into the output register from S_EMIT or S_DUMP, after its transaction, once the slot is free.
// Push, pop and count each pass through S_EMIT before the next item is taken; a dump of N elements gives
// N results, one element per cycle from the element store read port while the output slot is free.
// The item sequencer handles one item at a time; input is taken while a result waits.
// Reset clears front pointer, count and control; the element store is not cleared.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  typedef enum logic [1:0] {S_IDLE, S_EMIT, S_DUMP} state_t;

  state_t      state;
  idx_t        front;
  cnt_t        count;
  cnt_t        dump_idx;
  logic [1:0]  pend_status;
  logic [1:0]  pend_status_next;
  logic        pend_mem;
  mem_req_t    mem_req;
  logic [31:0] rd_data;
  logic        req_acc;
  logic        slot_free;
  logic        rsp_load;
  logic        full;
  logic        empty;
  logic        dump_last;

  assign req_ready = (state == S_IDLE);
  assign req_acc   = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;
  assign rsp_load  = slot_free && (state != S_IDLE);
  assign full      = (count == cnt_t'(CAPACITY));
  assign empty     = (count == '0);
  assign dump_last = (dump_idx == count - 1'b1);

  deq_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_comb begin
    unique case (req.opcode) inside
      OP_PUSH_FRONT, OP_PUSH_BACK:          pend_status_next = full ? ST_FULL : ST_OK;
      OP_POP_FRONT, OP_POP_BACK, OP_DUMP:   pend_status_next = empty ? ST_EMPTY : ST_OK;
      default:                              pend_status_next = ST_OK;
    endcase
  end

  always_comb begin
    mem_req = '0;
    mem_req.wr_data = req.push_value;
    if (req_acc) begin
      unique case (req.opcode)
        OP_PUSH_FRONT: begin
          mem_req.wr_en   = !full;
          mem_req.wr_addr = ring_dec(front);
        end
        OP_PUSH_BACK: begin
          mem_req.wr_en   = !full;
          mem_req.wr_addr = ring_pos(front, count);
        end
        OP_POP_FRONT: begin
          mem_req.rd_en   = !empty;
          mem_req.rd_addr = front;
        end
        OP_POP_BACK: begin
          mem_req.rd_en   = !empty;
          mem_req.rd_addr = ring_pos(front, count - 1'b1);
        end
        OP_DUMP: begin
          mem_req.rd_en   = !empty;
          mem_req.rd_addr = front;
        end
        default: ;
      endcase
    end else if (state == S_DUMP && slot_free && !dump_last) begin
      mem_req.rd_en   = 1'b1;
      mem_req.rd_addr = ring_pos(front, dump_idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            pend_status <= pend_status_next;
            pend_mem    <= !empty &&
                           (req.opcode == OP_POP_FRONT || req.opcode == OP_POP_BACK);
            state       <= (req.opcode == OP_DUMP && !empty) ? S_DUMP : S_EMIT;
            unique case (req.opcode)
              OP_PUSH_FRONT: begin
                if (!full) begin
                  front <= ring_dec(front);
                  count <= count + 1'b1;
                end
              end
              OP_PUSH_BACK: begin
                if (!full) begin
                  count <= count + 1'b1;
                end
              end
              OP_POP_FRONT: begin
                if (!empty) begin
                  front <= ring_pos(front, cnt_t'(1));
                  count <= count - 1'b1;
                end
              end
              OP_POP_BACK: begin
                if (!empty) begin
                  count <= count - 1'b1;
                end
              end
              OP_DUMP: begin
                if (!empty) begin
                  dump_idx <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            rsp.item_value   <= pend_mem ? rd_data : '0;
            rsp.occupancy    <= 7'(count);
            rsp.status       <= pend_status;
            rsp.last_result  <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (slot_free) begin
            rsp.item_value   <= rd_data;
            rsp.occupancy    <= 7'(count);
            rsp.status       <= ST_OK;
            rsp.last_result  <= dump_last;
            dump_idx         <= dump_idx + 1'b1;
            if (dump_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(CAPACITY))
    else $error("element count above capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (req_acc && !full && (req.opcode == OP_PUSH_FRONT || req.opcode == OP_PUSH_BACK))
    |=> count == $past(count) + 1'b1)
    else $error("accepted push did not grow the queue");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (req_acc && !empty && (req.opcode == OP_POP_FRONT || req.opcode == OP_POP_BACK))
    |=> count == $past(count) - 1'b1)
    else $error("accepted pop did not shrink the queue");

  a_partial_in_dump: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last_result) |-> state == S_DUMP)
    else $error("non-final result outside a dump");

endmodule
